/* hw/rtl/text_console_writer_defines.svh */
// ----------------------------------------------------------------------------
// text_console_writer_defines
// Assertion macros used by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, command codes and address helpers for the console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int TOP_W    = $clog2(ROWS);
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int POS_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_OUT
    } state_t;

    // logical row -> physical memory address through the row-offset ring
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [TOP_W-1:0] top
    );
        logic [ROW_W:0] sum;
        logic [ROW_W:0] prow;
        sum  = {1'b0, row} + (ROW_W+1)'(top);
        prow = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
        return ADDR_W'(prow * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen store with cursor, newline, wrap and scroll.
//
//   channel  | signals                               | dir
//   ---------+---------------------------------------+-----
//   input    | in_valid/in_stall, command..row       | in
//   result   | out_valid/out_stall, cursor_*, cell_* | out
//   config   | cfg_we, cfg_data (text attribute)     | in
//
// Put char, set cursor and read cell: via S_OUT into the output register.
// Scroll: a row-offset ring moves the screen; the recycled row is blanked
// through the memory write port, one row of COLS (80) cells.
// Clear: one cell per cycle through the write port, all ROWS*COLS (2000) cells.
// No clearing pass after reset. One word in flight; a new word is taken
// while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        command,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [COL_W-1:0]  col,
    input  wire logic [ROW_W-1:0]  row,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [COL_W-1:0]       cursor_col,
    output logic [ROW_W-1:0]       cursor_row,
    output logic [POS_W-1:0]       cursor_position,
    output logic [CHAR_W-1:0]      cell_char,
    output logic [ATTR_W-1:0]      cell_attr,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_data
);

    state_t              state_reg,  state_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [TOP_W-1:0]    top_reg,    top_next;
    logic [ADDR_W-1:0]   sweep_reg,  sweep_next;
    logic [ADDR_W-1:0]   sweep_end_reg, sweep_end_next;
    logic                rd_hit_reg, rd_hit_next;
    logic [ATTR_W-1:0]   attr_reg;
    logic                out_valid_reg;

    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [ATTR_W-1:0]   out_attr_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic                accept;
    logic                out_free;
    logic [COL_W:0]      col_inc;
    logic [ROW_W:0]      row_inc;
    logic                advance;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   top_base;
    logic [ADDR_W+ROW_W:0] pos_full;

    tcw_ram #(
        .DEPTH(CELLS),
        .WIDTH(CELL_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign col_inc  = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign row_inc  = {1'b0, cur_row_reg} + (ROW_W+1)'(1);
    assign cur_addr = phys_addr(cur_row_reg, cur_col_reg, top_reg);
    assign top_base = ADDR_W'(top_reg * ADDR_W'(COLS));
    assign pos_full = cur_row_reg * (ADDR_W+1)'(COLS) + (ADDR_W+ROW_W+1)'(cur_col_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        sweep_next     = sweep_reg;
        sweep_end_next = sweep_end_reg;
        rd_hit_next    = rd_hit_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = {char_code, attr_reg};
        ram_re         = 1'b0;
        ram_raddr      = phys_addr(row, col, top_reg);
        advance        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_OUT;
                    rd_hit_next = 1'b0;
                    case (cmd_t'(command))
                        CMD_PUT:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                cur_col_next = '0;
                                advance      = 1'b1;
                            end
                            else if (char_code != '0)
                            begin
                                ram_we = 1'b1;
                                if (col_inc >= (COL_W+1)'(COLS))
                                begin
                                    cur_col_next = '0;
                                    advance      = 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = col_inc[COL_W-1:0];
                                end
                            end
                            if (advance)
                            begin
                                if (row_inc >= (ROW_W+1)'(ROWS))
                                begin
                                    // old top row becomes the new bottom row
                                    top_next = (top_reg == TOP_W'(ROWS-1)) ? '0
                                             : top_reg + TOP_W'(1);
                                    sweep_next     = top_base;
                                    sweep_end_next = top_base + ADDR_W'(COLS-1);
                                    state_next     = S_SWEEP;
                                end
                                else
                                begin
                                    cur_row_next = row_inc[ROW_W-1:0];
                                end
                            end
                        end
                        CMD_SET:
                        begin
                            cur_col_next = ({1'b0, col} >= (COL_W+1)'(COLS))
                                         ? COL_W'(COLS-1) : col;
                            cur_row_next = ({1'b0, row} >= (ROW_W+1)'(ROWS))
                                         ? ROW_W'(ROWS-1) : row;
                        end
                        CMD_CLEAR:
                        begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            top_next       = '0;
                            sweep_next     = '0;
                            sweep_end_next = ADDR_W'(CELLS-1);
                            state_next     = S_SWEEP;
                        end
                        CMD_READ:
                        begin
                            rd_hit_next = ({1'b0, col} < (COL_W+1)'(COLS))
                                       && ({1'b0, row} < (ROW_W+1)'(ROWS));
                            ram_re      = rd_hit_next;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = {BLANK_CODE, attr_reg};
                if (sweep_reg == sweep_end_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            sweep_reg     <= '0;
            sweep_end_reg <= '0;
            rd_hit_reg    <= 1'b0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            sweep_reg     <= sweep_next;
            sweep_end_reg <= sweep_end_next;
            rd_hit_reg    <= rd_hit_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only when the output word is free
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_pos_reg  <= pos_full[POS_W-1:0];
            out_char_reg <= rd_hit_reg ? ram_rdata[CELL_W-1:ATTR_W] : '0;
            out_attr_reg <= rd_hit_reg ? ram_rdata[ATTR_W-1:0] : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_position = out_pos_reg;
    assign cell_char       = out_char_reg;
    assign cell_attr       = out_attr_reg;

    `TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1, ({1'b0, cur_col_reg} < (COL_W+1)'(COLS)) && ({1'b0, cur_row_reg} < (ROW_W+1)'(ROWS)), "cursor left the screen")
    `TCW_ASSERT_NOW(a_top_in_range, 1'b1, {1'b0, top_reg} < (TOP_W+1)'(ROWS), "row offset out of range")
    `TCW_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == S_OUT, "result word without finished command")
    `TCW_ASSERT_NEXT(a_one_in_flight, accept, state_reg != S_IDLE, "second word taken before result")

endmodule

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* verif/text_console_checker.sv */
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the command, result and attribute ports of the console writer.
// Keeps its own copy of the screen, cursor and attribute, works out the
// result word for every accepted command, and compares each result word
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_checker
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [1:0]        command,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [COL_W-1:0]  col,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [COL_W-1:0]  cursor_col,
    input  wire logic [ROW_W-1:0]  cursor_row,
    input  wire logic [POS_W-1:0]  cursor_position,
    input  wire logic [CHAR_W-1:0] cell_char,
    input  wire logic [ATTR_W-1:0] cell_attr,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_data,
    output int                     pending,
    output int                     fail_count
);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] glyph;
        logic [ATTR_W-1:0] tint;
    } console_word_t;

    logic [CHAR_W-1:0] screen_glyphs [CELLS];
    logic [ATTR_W-1:0] screen_tints  [CELLS];
    int                cur_c;
    int                cur_r;
    logic [ATTR_W-1:0] text_tint;
    console_word_t     due_words [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic match_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    function automatic void blank_cells(input int first, input int count);
        for (int i = first; i < first + count; i++)
        begin
            screen_glyphs[i] = BLANK_CODE;
            screen_tints[i]  = text_tint;
        end
    endfunction

    // runs one command on the local screen copy and returns its result word
    function automatic console_word_t console_step(input cmd_t op,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
        console_word_t res;
        int at;
        res.glyph = '0;
        res.tint  = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch != '0)
                begin
                    if (ch == NEWLINE_CODE)
                    begin
                        cur_c = 0;
                        cur_r++;
                    end
                    else
                    begin
                        at = cur_r * COLS + cur_c;
                        screen_glyphs[at] = ch;
                        screen_tints[at]  = text_tint;
                        cur_c++;
                    end
                    if (cur_c >= COLS)
                    begin
                        cur_c = 0;
                        cur_r++;
                    end
                    // past the bottom: everything moves up a row
                    if (cur_r >= ROWS)
                    begin
                        for (at = 0; at < CELLS - COLS; at++)
                        begin
                            screen_glyphs[at] = screen_glyphs[at + COLS];
                            screen_tints[at]  = screen_tints[at + COLS];
                        end
                        blank_cells(CELLS - COLS, COLS);
                        cur_r = ROWS - 1;
                    end
                end
            end
            CMD_SET:
            begin
                cur_c = (c >= COLS) ? COLS - 1 : int'(c);
                cur_r = (r >= ROWS) ? ROWS - 1 : int'(r);
            end
            CMD_CLEAR:
            begin
                blank_cells(0, CELLS);
                cur_c = 0;
                cur_r = 0;
            end
            CMD_READ:
            begin
                if (c < COLS && r < ROWS)
                begin
                    res.glyph = screen_glyphs[r * COLS + c];
                    res.tint  = screen_tints[r * COLS + c];
                end
            end
        endcase
        res.col = COL_W'(cur_c);
        res.row = ROW_W'(cur_r);
        res.pos = POS_W'(cur_r * COLS + cur_c);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_word_t want;
        if (!rst_n)
        begin
            due_words.delete();
            cur_c     = 0;
            cur_r     = 0;
            text_tint = ATTR_RESET;
            pending  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_words.size() == 0)
                    report_mismatch("result word with nothing due");
                else
                begin
                    want = due_words.pop_front();
                    match_field("cursor_col", cursor_col, want.col);
                    match_field("cursor_row", cursor_row, want.row);
                    match_field("cursor_position", cursor_position, want.pos);
                    match_field("cell_char", cell_char, want.glyph);
                    match_field("cell_attr", cell_attr, want.tint);
                end
            end
            if (cfg_we)
                text_tint = cfg_data;
            if (in_valid && !in_stall)
                due_words.push_back(console_step(cmd_t'(command), char_code, col, row));
            pending <= due_words.size();
        end
    end

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the console writer with a directed opener (clear, wrap, scroll,
// newline, saturated cursor, out-of-range reads, ignored zero byte) and then
// random command streams under several text attributes, with random gaps and
// stalls on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import tcw_pkg::*;

    localparam int ITEMS_PER_PHASE = 240;
    localparam int PHASES          = 6;
    localparam int IDLE_LIMIT      = 10000;
    localparam int JAM_CYCLES      = 250;
    localparam int SETTLE_CYCLES   = 100;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [1:0]        command   = CMD_PUT;
    logic [CHAR_W-1:0] char_code = '0;
    logic [COL_W-1:0]  col       = '0;
    logic [ROW_W-1:0]  row       = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [ATTR_W-1:0] cfg_data  = '0;

    logic              in_stall;
    logic              out_valid;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    always #1 clk = ~clk;

    text_console_writer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .char_code       (char_code),
        .col             (col),
        .row             (row),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    text_console_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .char_code       (char_code),
        .col             (col),
        .row             (row),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    // valid stays high after an accept; the next call either lowers it or
    // replaces the payload, never both in one step
    task automatic send_word(input cmd_t op, input logic [CHAR_W-1:0] ch,
                             input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= op;
        char_code <= ch;
        col       <= c;
        row       <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_word();
        int                pick;
        cmd_t              op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        pick = $urandom_range(0, 199);
        ch   = CHAR_W'($urandom);
        c    = COL_W'($urandom);
        r    = ROW_W'($urandom);
        if (pick < 2)
            op = CMD_CLEAR;
        else if (pick < 30)
        begin
            op = CMD_READ;
            if (pick < 26)
            begin
                c = COL_W'($urandom_range(0, COLS - 1));
                r = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end
        else if (pick < 50)
        begin
            op = CMD_SET;
            // bottom row often, so wraps run into scrolls
            if (pick < 38)
            begin
                c = COL_W'($urandom_range(COLS - 12, COLS - 1));
                r = ROW_W'(ROWS - 1);
            end
            else if (pick < 46)
            begin
                c = COL_W'($urandom_range(0, COLS - 1));
                r = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end
        else
        begin
            op = CMD_PUT;
            if (pick < 66)
                ch = NEWLINE_CODE;
            else if (pick < 70)
                ch = '0;
            else if (pick >= 80)
                ch = CHAR_W'($urandom_range(33, 126));
        end
        send_word(op, ch, c, r);
    endtask

    // attribute changes only with nothing in flight
    task automatic load_attribute(input logic [ATTR_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin : result_sink
        int hold;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            // two long hold-offs so the writer backs up into its input
            if (taken == 400 || taken == 1000)
                hold = JAM_CYCLES;
            else
                hold = calm ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clear first so every cell holds a defined value before any read
        send_word(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_word(CMD_PUT, 8'hFF, 7'd0, 5'd0);
        send_word(CMD_PUT, 8'h01, 7'd127, 5'd31);
        send_word(CMD_PUT, 8'h00, 7'd0, 5'd0);
        send_word(CMD_PUT, 8'h41, 7'd0, 5'd0);
        send_word(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_word(CMD_READ, 8'h00, 7'd1, 5'd0);
        send_word(CMD_READ, 8'h00, 7'd2, 5'd0);
        // last cell: wrap and scroll in one word
        send_word(CMD_SET, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
        send_word(CMD_PUT, 8'h5A, 7'd0, 5'd0);
        send_word(CMD_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 2));
        send_word(CMD_READ, 8'h00, 7'd0, 5'(ROWS - 1));
        // saturated cursor, then newline on the last row
        send_word(CMD_SET, 8'hFF, 7'd127, 5'd31);
        send_word(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);
        send_word(CMD_READ, 8'h00, 7'd127, 5'd31);
        send_word(CMD_READ, 8'h00, 7'(COLS), 5'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'(ROWS));
        send_word(CMD_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 3));
        send_word(CMD_SET, 8'h00, 7'd0, 5'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 1)
                load_attribute('0);
            else if (phase == 2)
                load_attribute('1);
            else if (phase > 2)
                load_attribute(ATTR_W'($urandom));
            calm = (phase == 3);
            repeat (ITEMS_PER_PHASE) send_random_word();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
verif/text_console_checker.sv
verif/tb.sv
